// File: rtl/core/sjf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_pkg
// Shared constants, types and the rounding step function of the surface
// Jacobian frame pipeline.
// ----------------------------------------------------------------------------
package sjf_pkg;

  localparam int SQ_STAGES  = 64;   // one root bit per stage
  localparam int UNIT_FRAC  = 30;   // Q2.30 unit components
  localparam int DIV_STAGES = UNIT_FRAC + 1;

  localparam logic [1:0] DIMS_CURVE = 2'd1;
  localparam logic [1:0] DIMS_RESET = 2'd2;

  localparam logic signed [63:0] UNIT_ONE   = 64'sd1 <<< UNIT_FRAC;
  localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (UNIT_FRAC - 1);

  typedef struct packed {
    logic             curve;
    logic [2:0]       c_neg;
    logic [2:0][63:0] c_mag;
    logic [2:0]       a_neg;
    logic [2:0][31:0] a_mag;
  } side_t;

  typedef struct packed {
    logic        curve;
    logic        status;
    logic [47:0] len;
    logic [2:0]  c_neg;
    logic [2:0]  a_neg;
  } div_side_t;

  typedef struct packed {
    logic [47:0]      length;
    logic [8:0][31:0] axis;
    logic             status;
  } frame_t;

  // Q4.60 to Q2.30, round half up, clamp to plus/minus one
  function automatic logic [31:0] round30(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + ROUND_HALF) >>> UNIT_FRAC;
    if (t > UNIT_ONE) begin
      t = UNIT_ONE;
    end else if (t < -UNIT_ONE) begin
      t = -UNIT_ONE;
    end
    return t[31:0];
  endfunction

endpackage

// File: rtl/core/sjf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_front
// Six-stage front end: cross product, tangent norm square, and the split
// squaring of the cross product components into a 128-bit radicand.
// ----------------------------------------------------------------------------
module sjf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic              curve,
  input  logic [5:0][31:0]  tan,
  output logic              out_valid,
  output logic [127:0]      rad,
  output logic [63:0]       rad1,
  output sjf_pkg::side_t    side
);
  import sjf_pkg::*;

  logic [5:0] v;
  logic signed [31:0] a [3];
  logic signed [31:0] b [3];

  logic signed [63:0] p1 [6];
  logic [63:0]        sq1 [3];
  side_t              side1, side2, side3, side4, side5;
  logic signed [63:0] c2 [3];
  logic [63:0]        s2, s3, s4, s5;
  logic [63:0]        ll4 [3];
  logic [63:0]        lh4 [3];
  logic [63:0]        hh4 [3];
  logic [127:0]       sq5 [3];

  assign a[0] = tan[0];
  assign a[1] = tan[1];
  assign a[2] = curve ? 32'sd0 : tan[2];   // plane curve: drop z
  assign b[0] = tan[3];
  assign b[1] = tan[4];
  assign b[2] = tan[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // F1: products
      p1[0] <= a[1] * b[2];
      p1[1] <= a[2] * b[1];
      p1[2] <= a[2] * b[0];
      p1[3] <= a[0] * b[2];
      p1[4] <= a[0] * b[1];
      p1[5] <= a[1] * b[0];
      side1.curve <= curve;
      side1.c_neg <= '0;
      side1.c_mag <= '0;
      for (int i = 0; i < 3; i++) begin
        sq1[i]          <= a[i] * a[i];
        side1.a_neg[i]  <= a[i][31];
        side1.a_mag[i]  <= a[i][31] ? 32'(-a[i]) : 32'(a[i]);
      end
      // F2: cross product, wrapped to 64 bits
      c2[0] <= p1[0] - p1[1];
      c2[1] <= p1[2] - p1[3];
      c2[2] <= p1[4] - p1[5];
      s2    <= sq1[0] + sq1[1] + sq1[2];
      side2 <= side1;
      // F3: sign and magnitude
      side3.curve <= side2.curve;
      side3.a_neg <= side2.a_neg;
      side3.a_mag <= side2.a_mag;
      for (int i = 0; i < 3; i++) begin
        side3.c_neg[i] <= c2[i][63];
        side3.c_mag[i] <= c2[i][63] ? 64'(-c2[i]) : 64'(c2[i]);
      end
      s3 <= s2;
      // F4: partial products of each square
      for (int i = 0; i < 3; i++) begin
        ll4[i] <= side3.c_mag[i][31:0]  * side3.c_mag[i][31:0];
        lh4[i] <= side3.c_mag[i][31:0]  * side3.c_mag[i][63:32];
        hh4[i] <= side3.c_mag[i][63:32] * side3.c_mag[i][63:32];
      end
      side4 <= side3;
      s4    <= s3;
      // F5: assemble squares
      for (int i = 0; i < 3; i++) begin
        sq5[i] <= {hh4[i], 64'd0} + {31'd0, lh4[i], 33'd0} + {64'd0, ll4[i]};
      end
      side5 <= side4;
      s5    <= s4;
      // F6: sum of squares
      rad  <= sq5[0] + sq5[1] + sq5[2];
      rad1 <= s5;
      side <= side5;
    end
  end

  assign out_valid = v[5];

endmodule

// File: rtl/core/sjf_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_sqrt
// Pipelined integer square root, floor(sqrt) of a 128-bit radicand, one
// restoring step per stage.
// ----------------------------------------------------------------------------
module sjf_sqrt (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  logic [127:0] rad_in,
  output logic         out_valid,
  output logic [63:0]  root_out
);
  import sjf_pkg::*;

  logic [SQ_STAGES-1:0] v;
  logic [127:0] rad  [SQ_STAGES];
  logic [65:0]  rem  [SQ_STAGES];
  logic [63:0]  root [SQ_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[SQ_STAGES-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    logic [127:0] rad_src;
    logic [65:0]  rem_src;
    logic [63:0]  root_src;
    logic [67:0]  x;
    logic [67:0]  trial;
    logic         ge;

    if (k == 0) begin : g_first
      assign rad_src  = rad_in;
      assign rem_src  = '0;
      assign root_src = '0;
    end else begin : g_next
      assign rad_src  = rad[k-1];
      assign rem_src  = rem[k-1];
      assign root_src = root[k-1];
    end

    // bring down the next two radicand bits
    assign x     = {rem_src, rad_src[127-2*k -: 2]};
    assign trial = {2'b00, root_src, 2'b01};
    assign ge    = (x >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k]  <= rad_src;
        rem[k]  <= ge ? 66'(x - trial) : x[65:0];
        root[k] <= {root_src[62:0], ge};
      end
    end
  end

  assign out_valid = v[SQ_STAGES-1];
  assign root_out  = root[SQ_STAGES-1];

endmodule

// File: rtl/core/sjf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_div
// Pipelined unit divider: floor(m * 2^30 / r) for m not above r, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module sjf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] m_in,
  input  logic [63:0] r_in,
  output logic        out_valid,
  output logic [30:0] q_out
);
  import sjf_pkg::*;

  logic [DIV_STAGES-1:0] v;
  logic [63:0] rem [DIV_STAGES];
  logic [63:0] r   [DIV_STAGES];
  logic [30:0] q   [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[DIV_STAGES-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [64:0] x;
    logic [63:0] r_src;
    logic [30:0] q_src;
    logic        ge;

    if (k == 0) begin : g_first
      assign x     = {1'b0, m_in};
      assign r_src = r_in;
      assign q_src = '0;
    end else begin : g_next
      assign x     = {rem[k-1], 1'b0};
      assign r_src = r[k-1];
      assign q_src = q[k-1];
    end

    assign ge = (x >= {1'b0, r_src});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? 64'(x - {1'b0, r_src}) : x[63:0];
        r[k]   <= r_src;
        q[k]   <= {q_src[29:0], ge};
      end
    end
  end

  assign out_valid = v[DIV_STAGES-1];
  assign q_out     = q[DIV_STAGES-1];

endmodule

// File: rtl/core/sjf_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_frame
// Three-stage back end: signed unit vectors, second axis products, and
// rounding and assembly of the result item.
// ----------------------------------------------------------------------------
module sjf_frame (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  sjf_pkg::div_side_t  side,
  input  logic [2:0][30:0]    q_c,
  input  logic [2:0][30:0]    q_a,
  output logic                out_valid,
  output sjf_pkg::frame_t     frame
);
  import sjf_pkg::*;

  logic [2:0] v;
  div_side_t side_u, side_m;
  logic signed [31:0] nu [3];
  logic signed [31:0] au [3];
  logic signed [31:0] nm [3];
  logic signed [31:0] am [3];
  logic signed [63:0] pm [6];
  frame_t             frame_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], in_valid};
    end
  end

  // assemble; degenerate items leave every field zero but status
  always_comb begin
    frame_next = '0;
    if (side_m.status) begin
      frame_next.status = 1'b1;
    end else if (side_m.curve) begin
      frame_next.length  = side_m.len;
      frame_next.axis[0] = am[0];
      frame_next.axis[1] = am[1];
      frame_next.axis[3] = am[1];
      frame_next.axis[4] = 32'(-am[0]);
    end else begin
      frame_next.length = side_m.len;
      for (int i = 0; i < 3; i++) begin
        frame_next.axis[i]     = am[i];
        frame_next.axis[6 + i] = nm[i];
      end
      frame_next.axis[3] = round30(pm[0] - pm[1]);
      frame_next.axis[4] = round30(pm[2] - pm[3]);
      frame_next.axis[5] = round30(pm[4] - pm[5]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // apply signs
      side_u <= side;
      for (int i = 0; i < 3; i++) begin
        nu[i] <= side.c_neg[i] ? (32'd0 - {1'b0, q_c[i]}) : {1'b0, q_c[i]};
        au[i] <= side.a_neg[i] ? (32'd0 - {1'b0, q_a[i]}) : {1'b0, q_a[i]};
      end
      // normal cross first axis
      side_m <= side_u;
      pm[0]  <= nu[1] * au[2];
      pm[1]  <= nu[2] * au[1];
      pm[2]  <= nu[2] * au[0];
      pm[3]  <= nu[0] * au[2];
      pm[4]  <= nu[0] * au[1];
      pm[5]  <= nu[1] * au[0];
      for (int i = 0; i < 3; i++) begin
        nm[i] <= nu[i];
        am[i] <= au[i];
      end
      frame <= frame_next;
    end
  end

  assign out_valid = v[2];

endmodule

// File: rtl/core/surface_jacobian_frame_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// surface_jacobian_frame_unit
// Surface Jacobian length and orthonormal local frame from tangent columns.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries two Q16.16 tangent columns.
//   Output channel (out_valid / out_stall) returns the Q32.16 length, nine
//   Q2.30 frame components and a degenerate flag, one item per input item.
//   The cfg channel (cfg_valid / cfg_ready) writes surface_dims; write it
//   only while no items are in flight.
//   Throughput: one item per cycle while in_stall is low. The path from
//   acceptance to out_valid runs through the 6-stage front end, the 64-stage
//   bit-per-stage square root, the 31-stage dividers, 3 frame stages and the
//   output register.
//   Reset (rst, synchronous) empties the pipeline and sets surface_dims to 2.
//   When out_stall holds a result, one more item lands in a skid register;
//   then in_stall rises and the whole pipeline freezes until the output
//   register drains. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module surface_jacobian_frame_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] tan1_x,
  input  logic signed [31:0] tan1_y,
  input  logic signed [31:0] tan1_z,
  input  logic signed [31:0] tan2_x,
  input  logic signed [31:0] tan2_y,
  input  logic signed [31:0] tan2_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [47:0]        surface_length,
  output logic signed [31:0] axis1_x,
  output logic signed [31:0] axis1_y,
  output logic signed [31:0] axis1_z,
  output logic signed [31:0] axis2_x,
  output logic signed [31:0] axis2_y,
  output logic signed [31:0] axis2_z,
  output logic signed [31:0] axis3_x,
  output logic signed [31:0] axis3_y,
  output logic signed [31:0] axis3_z,
  output logic               status
);
  import sjf_pkg::*;

  logic [1:0]      surface_dims;
  logic            en;
  logic [5:0][31:0] tan;

  logic            f_valid;
  logic [127:0]    f_rad;
  logic [63:0]     f_rad1;
  side_t           f_side;

  side_t           sd [SQ_STAGES];
  logic            s_valid;
  logic [63:0]     root_main;
  logic [63:0]     root_tan;
  div_side_t       dside_in;
  div_side_t       dd [DIV_STAGES];

  logic            d_valid;
  logic [2:0][30:0] q_c;
  logic [2:0][30:0] q_a;

  logic            b_valid;
  frame_t          b_frame;

  frame_t          out_q;
  frame_t          skid_q;
  logic            skid_valid;
  logic            take;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_dims <= DIMS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      surface_dims <= cfg_data;
    end
  end

  // freeze everything while the skid register holds an item
  assign en       = !skid_valid;
  assign in_stall = skid_valid;
  assign tan      = {tan2_z, tan2_y, tan2_x, tan1_z, tan1_y, tan1_x};

  sjf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .curve     (surface_dims == DIMS_CURVE),
    .tan       (tan),
    .out_valid (f_valid),
    .rad       (f_rad),
    .rad1      (f_rad1),
    .side      (f_side)
  );

  sjf_sqrt u_sqrt_main (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .rad_in    (f_rad),
    .out_valid (s_valid),
    .root_out  (root_main)
  );

  sjf_sqrt u_sqrt_tan (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .rad_in    ({64'd0, f_rad1}),
    .out_valid (),
    .root_out  (root_tan)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= f_side;
      for (int i = 1; i < SQ_STAGES; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  // length and degenerate flag, known once the roots are out
  always_comb begin
    dside_in.curve = sd[SQ_STAGES-1].curve;
    dside_in.c_neg = sd[SQ_STAGES-1].c_neg;
    dside_in.a_neg = sd[SQ_STAGES-1].a_neg;
    if (sd[SQ_STAGES-1].curve) begin
      dside_in.status = (root_tan == 64'd0);
      dside_in.len    = root_tan[47:0];
    end else begin
      dside_in.status = (root_main == 64'd0);
      dside_in.len    = root_main[63:16];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    if (i == 0) begin : g_lead
      sjf_div u_div_c (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .in_valid  (s_valid),
        .m_in      (sd[SQ_STAGES-1].c_mag[i]),
        .r_in      (root_main),
        .out_valid (d_valid),
        .q_out     (q_c[i])
      );
    end else begin : g_rest
      sjf_div u_div_c (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .in_valid  (s_valid),
        .m_in      (sd[SQ_STAGES-1].c_mag[i]),
        .r_in      (root_main),
        .out_valid (),
        .q_out     (q_c[i])
      );
    end

    sjf_div u_div_a (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (s_valid),
      .m_in      ({32'd0, sd[SQ_STAGES-1].a_mag[i]}),
      .r_in      (root_tan),
      .out_valid (),
      .q_out     (q_a[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= dside_in;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dd[i] <= dd[i-1];
      end
    end
  end

  sjf_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .side      (dd[DIV_STAGES-1]),
    .q_c       (q_c),
    .q_a       (q_a),
    .out_valid (b_valid),
    .frame     (b_frame)
  );

  // output register with one skid entry
  assign take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (b_valid) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (b_valid) begin
      if (!out_valid || take) begin
        out_q <= b_frame;
      end else begin
        skid_q <= b_frame;
      end
    end
  end

  assign surface_length = out_q.length;
  assign axis1_x        = out_q.axis[0];
  assign axis1_y        = out_q.axis[1];
  assign axis1_z        = out_q.axis[2];
  assign axis2_x        = out_q.axis[3];
  assign axis2_y        = out_q.axis[4];
  assign axis2_z        = out_q.axis[5];
  assign axis3_x        = out_q.axis[6];
  assign axis3_y        = out_q.axis[7];
  assign axis3_z        = out_q.axis[8];
  assign status         = out_q.status;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid filled without a held output");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (surface_length == 48'd0 && axis1_x == 32'sd0
                               && axis2_y == 32'sd0 && axis3_z == 32'sd0))
    else $error("degenerate item carries nonzero frame");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (axis2_x <= 32'sd1073741824 && axis2_x >= -32'sd1073741824
                   && axis1_x <= 32'sd1073741824 && axis1_x >= -32'sd1073741824))
    else $error("unit component out of range");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for surface_jacobian_frame_unit: drives tangent columns
// in curve and surface mode, predicts length, frame and status per item, and
// compares every output item in order under random idling and back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import sjf_pkg::*;

  localparam int LATENCY   = 105;
  localparam int HOLD_LONG = 400;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_data = DIMS_RESET;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [5:0][31:0]   tan_bus = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [47:0]        surface_length;
  logic signed [31:0] axis1_x, axis1_y, axis1_z;
  logic signed [31:0] axis2_x, axis2_y, axis2_z;
  logic signed [31:0] axis3_x, axis3_y, axis3_z;
  logic               status;

  surface_jacobian_frame_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .tan1_x(tan_bus[0]), .tan1_y(tan_bus[1]), .tan1_z(tan_bus[2]),
    .tan2_x(tan_bus[3]), .tan2_y(tan_bus[4]), .tan2_z(tan_bus[5]),
    .out_valid(out_valid), .out_stall(out_stall),
    .surface_length(surface_length),
    .axis1_x(axis1_x), .axis1_y(axis1_y), .axis1_z(axis1_z),
    .axis2_x(axis2_x), .axis2_y(axis2_y), .axis2_z(axis2_z),
    .axis3_x(axis3_x), .axis3_y(axis3_y), .axis3_z(axis3_z),
    .status(status)
  );

  always #1 clk = ~clk;

  frame_t     frame_queue[$];
  logic [1:0] dims_now = DIMS_RESET;
  int         errors = 0;
  int         frames_seen = 0;
  int         degenerate_seen = 0;
  int         curve_items = 0;
  int         surface_items = 0;
  bit         idle_on = 1'b1;
  bit         hold_req = 1'b0;
  int         hold_cnt = 0;

  function automatic logic [63:0] isqrt128(input logic [127:0] n);
    logic [63:0]  root;
    logic [63:0]  t;
    logic [127:0] sq;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      t  = root | (64'd1 << b);
      sq = {64'd0, t} * {64'd0, t};
      if (sq <= n) root = t;
    end
    return root;
  endfunction

  // sign(c) * floor(|c| * 2^30 / r), quotient limited to 31 bits
  function automatic logic signed [63:0] unit_comp(input logic signed [63:0] c,
                                                   input logic [63:0] r);
    logic [63:0]  m;
    logic [127:0] q;
    if (r == 0) return 0;
    m = c[63] ? -c : c;
    q = {34'd0, m, 30'd0} / {64'd0, r};
    if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
    return c[63] ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic logic signed [63:0] round_q30(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + 64'sd536870912) >>> 30;
    if (t > 64'sd1073741824) t = 64'sd1073741824;
    if (t < -64'sd1073741824) t = -64'sd1073741824;
    return t;
  endfunction

  function automatic logic [127:0] sq64(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? -v : v;
    return {64'd0, m} * {64'd0, m};
  endfunction

  function automatic frame_t predict_frame(input logic [1:0] dims,
                                           input logic [5:0][31:0] tan);
    frame_t             f;
    logic signed [63:0] a[3], b[3], c[3], ax[9];
    logic [63:0]        r, r1;
    for (int i = 0; i < 3; i++) begin
      a[i] = $signed(tan[i]);
      b[i] = $signed(tan[3+i]);
    end
    for (int i = 0; i < 9; i++) ax[i] = 0;
    f = '0;
    if (dims == DIMS_CURVE) begin
      r = isqrt128(sq64(a[0]) + sq64(a[1]));
      if (r == 0) begin
        f.status = 1'b1;
      end else begin
        f.length = r[47:0];
        ax[0] = unit_comp(a[0], r);
        ax[1] = unit_comp(a[1], r);
        ax[3] = ax[1];
        ax[4] = -ax[0];
      end
    end else begin
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
      r = isqrt128(sq64(c[0]) + sq64(c[1]) + sq64(c[2]));
      if (r == 0) begin
        f.status = 1'b1;
      end else begin
        f.length = r[63:16];
        r1 = isqrt128(sq64(a[0]) + sq64(a[1]) + sq64(a[2]));
        for (int i = 0; i < 3; i++) begin
          ax[6+i] = unit_comp(c[i], r);
          ax[i]   = unit_comp(a[i], r1);
        end
        ax[3] = round_q30(ax[7] * ax[2] - ax[8] * ax[1]);
        ax[4] = round_q30(ax[8] * ax[0] - ax[6] * ax[2]);
        ax[5] = round_q30(ax[6] * ax[1] - ax[7] * ax[0]);
      end
    end
    for (int i = 0; i < 9; i++) f.axis[i] = ax[i][31:0];
    return f;
  endfunction

  // predict on every accepted input item
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      frame_queue.push_back(predict_frame(dims_now, tan_bus));
      if (dims_now == DIMS_CURVE) curve_items++;
      else surface_items++;
    end
  end

  // compare every accepted output item with the oldest prediction
  always @(posedge clk) begin
    frame_t exp_f;
    frame_t got;
    if (!rst && out_valid && !out_stall) begin
      got.length = surface_length;
      got.axis[0] = axis1_x; got.axis[1] = axis1_y; got.axis[2] = axis1_z;
      got.axis[3] = axis2_x; got.axis[4] = axis2_y; got.axis[5] = axis2_z;
      got.axis[6] = axis3_x; got.axis[7] = axis3_y; got.axis[8] = axis3_z;
      got.status = status;
      frames_seen++;
      if (status) degenerate_seen++;
      if (frame_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected output item, expected none, actual length %h",
                 $time, surface_length);
      end else begin
        exp_f = frame_queue.pop_front();
        if (got.length !== exp_f.length) begin
          errors++;
          $display("%0t: surface_length expected %h actual %h",
                   $time, exp_f.length, got.length);
        end
        for (int i = 0; i < 9; i++) begin
          if (got.axis[i] !== exp_f.axis[i]) begin
            errors++;
            $display("%0t: axis%0d_%s expected %h actual %h", $time, i / 3 + 1,
                     (i % 3 == 0) ? "x" : (i % 3 == 1) ? "y" : "z",
                     exp_f.axis[i], got.axis[i]);
          end
        end
        if (got.status !== exp_f.status) begin
          errors++;
          $display("%0t: status expected %b actual %b",
                   $time, exp_f.status, got.status);
        end
      end
    end
  end

  // receiver: random stall, long hold on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = HOLD_LONG;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 25);
    end
  end

  task automatic send_item(input logic [5:0][31:0] tan);
    while (idle_on && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    tan_bus  <= tan;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (frame_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_dims(input logic [1:0] value);
    drain_pipe();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    dims_now = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom_range(262143) - 131072;
      7: begin
        case ($urandom_range(4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'd1;
          3: return 32'hFFFF_FFFF;
          default: return 32'd0;
        endcase
      end
      8:       return 32'd0;
      default: return 32'h0001_0000 + $urandom_range(4095) - 2048;
    endcase
  endfunction

  function automatic logic [5:0][31:0] rand_tan();
    logic [5:0][31:0] t;
    for (int i = 0; i < 6; i++) t[i] = rand_comp();
    // parallel tangents give a degenerate surface
    if ($urandom_range(9) == 0) begin
      t[3] = t[0]; t[4] = t[1]; t[5] = t[2];
    end
    return t;
  endfunction

  task automatic test_curve_directed();
    write_dims(DIMS_CURVE);
    send_item({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0001_0000});
    send_item({32'd0, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0});
    send_item({32'd0, 32'd0, 32'd0, 32'h1234, 32'h8000_0000, 32'h8000_0000});
    send_item({32'd0, 32'd0, 32'd0, 32'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_item({32'd9, 32'd9, 32'd9, 32'h7FFF_FFFF, 32'd0, 32'd0});
    send_item({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1});
    send_item({32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'h0003_0000});
  endtask

  task automatic test_surface_directed();
    write_dims(DIMS_RESET);
    send_item({32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'h0001_0000});
    send_item({32'd0, 32'h0002_0000, 32'd0, 32'd0, 32'h0001_0000, 32'd0});
    send_item({32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    send_item({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    send_item({32'h8000_0000, 32'd0, 32'h7FFF_FFFF,
               32'd0, 32'h8000_0000, 32'h7FFF_FFFF});
    send_item({32'd3, 32'd2, 32'd1, 32'd3, 32'd2, 32'd1});
    send_item({32'h0001_0000, 32'h0002_0000, 32'd0, 32'd0, 32'd0, 32'd0});
    send_item({32'd0, 32'd0, 32'd1, 32'd0, 32'd1, 32'd0});
    send_item('0);
  endtask

  task automatic test_random(input logic [1:0] dims, input int count);
    write_dims(dims);
    for (int n = 0; n < count; n++) send_item(rand_tan());
  endtask

  task automatic test_no_idle(input int count);
    idle_on = 1'b0;
    for (int n = 0; n < count; n++) send_item(rand_tan());
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure(input int count);
    hold_req = 1'b1;
    for (int n = 0; n < count; n++) send_item(rand_tan());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_surface_directed();
    test_curve_directed();
    test_random(DIMS_CURVE, 400);
    test_no_idle(150);
    test_random(2'd0, 200);
    test_random(2'd3, 200);
    test_random(DIMS_RESET, 450);
    test_backpressure(200);
    drain_pipe();
    $display("Covered %0d curve and %0d surface items, %0d output items checked",
             curve_items, surface_items, frames_seen);
    $display("with %0d degenerate frames, all surface_dims codes and long stalls",
             degenerate_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d output items still outstanding", frame_queue.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: surface_jacobian_frame_unit.f
rtl/core/sjf_pkg.sv
rtl/core/sjf_front.sv
rtl/core/sjf_sqrt.sv
rtl/core/sjf_div.sv
rtl/core/sjf_frame.sv
rtl/core/surface_jacobian_frame_unit.sv
verif/testbench.sv
